/* hdl/wcgs_pkg.sv */
// ----------------------------------------------------------------------------
// wcgs_pkg
// Shared widths, register codes and types of the widest clear gap steering
// unit.
// ----------------------------------------------------------------------------
package wcgs_pkg;

  localparam int MAX_SAMPLES = 1024;

  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = IDX_W + 1;

  localparam int RANGE_W = 16;
  localparam int THR_W   = 16;
  localparam int SPAN_W  = 7;
  localparam int NEUT_W  = 8;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(40);
  localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(30);
  localparam logic [NEUT_W-1:0] NEUT_RESET = NEUT_W'(90);

  // steering numerator: span*center_twice + (neutral - span)*length
  localparam int DIFF_W = NEUT_W + 1;
  localparam int P1_W   = SPAN_W + SUM_W;
  localparam int P2_W   = DIFF_W + CNT_W + 1;
  localparam int NUM_W  = ((P1_W > P2_W) ? P1_W : P2_W) + 1;
  localparam int MAG_W  = NUM_W - 1;
  localparam int ITER_W = $clog2(MAG_W);

  // result field widths
  localparam int START_W  = 10;
  localparam int LENGTH_W = 11;
  localparam int CENTER_W = 11;
  localparam int STEER_W  = 10;

  localparam int S_TDATA_W = 16;
  localparam int OUT_BITS  = 2 * START_W + LENGTH_W + CENTER_W + STEER_W + 1;
  localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_HALF_SPAN = 2'd1,
    CFG_NEUTRAL   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0] run_start;
    logic [IDX_W-1:0] run_end;
    logic [CNT_W-1:0] run_length;
    logic [SUM_W-1:0] center_twice;
    logic [CNT_W-1:0] scan_length;
    logic             too_long;
  } scan_sum_t;

  typedef struct packed {
    logic start;
    logic ack;
  } steer_ctl_t;

endpackage

/* hdl/widest_clear_gap_steering_unit.sv */
// ----------------------------------------------------------------------------
// widest_clear_gap_steering_unit
// Finds the longest run of clear range samples in a scan and derives the
// gap bounds, center and a steering value.
// ----------------------------------------------------------------------------
// Ordinary samples transfer at one per cycle while no steering result is pending.
// A sample with tlast starts the steering divide: the result passes through
// one capture step, two setup steps, one restoring divide step per quotient
// bit for 21 bits and one output load, and no sample is taken until the
// result is in the output register.
// Reset (synchronous, active high) clears the scan and restores registers
// to threshold 40, half span 30, neutral 90.
// ----------------------------------------------------------------------------
module widest_clear_gap_steering_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wcgs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wcgs_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [wcgs_pkg::S_TDATA_W-1:0]      s_tdata,  // range_value
  input  logic                                s_tlast,  // last_sample
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // run_start, run_end, run_length, center_twice, steer_command, too_long
  output logic [wcgs_pkg::M_TDATA_W-1:0]      m_tdata
);
  import wcgs_pkg::*;

  logic [THR_W-1:0]          clear_threshold;
  logic [SPAN_W-1:0]         steer_half_span;
  logic [NEUT_W-1:0]         steer_neutral;
  logic                      take;
  scan_sum_t                 summary;
  logic                      summary_valid;
  steer_ctl_t                ctl;
  logic                      steer_idle;
  logic                      steer_done;
  logic signed [STEER_W-1:0] steer_command;
  logic                      out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_threshold <= THR_RESET;
      steer_half_span <= SPAN_RESET;
      steer_neutral   <= NEUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: clear_threshold <= cfg_data[THR_W-1:0];
        CFG_HALF_SPAN: steer_half_span <= cfg_data[SPAN_W-1:0];
        CFG_NEUTRAL:   steer_neutral   <= cfg_data[NEUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s_tready = steer_idle && !summary_valid;
  assign take     = s_tvalid && s_tready;

  wcgs_scan u_scan (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .range_value     (s_tdata[RANGE_W-1:0]),
    .last_sample     (s_tlast),
    .clear_threshold (clear_threshold),
    .summary         (summary),
    .summary_valid   (summary_valid)
  );

  assign out_load  = steer_done && (!m_tvalid || m_tready);
  assign ctl.start = summary_valid;
  assign ctl.ack   = out_load;

  wcgs_steer u_steer (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .half_span     (steer_half_span),
    .neutral       (steer_neutral),
    .center_twice  (summary.center_twice),
    .scan_length   (summary.scan_length),
    .idle          (steer_idle),
    .done          (steer_done),
    .steer_command (steer_command)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= M_TDATA_W'({summary.too_long,
                             steer_command,
                             CENTER_W'(summary.center_twice),
                             LENGTH_W'(summary.run_length),
                             START_W'(summary.run_end),
                             START_W'(summary.run_start)});
    end
  end

`ifndef NO_ASSERTIONS
  a_last_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (take && s_tlast) |=> !s_tready)
    else $error("sample taken while a scan result is pending");

  a_summary_finds_idle: assert property (@(posedge clk) disable iff (rst)
    summary_valid |-> steer_idle)
    else $error("scan summary arrived while steering unit busy");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_tvalid && steer_idle))
    else $error("result load did not reach output register");
`endif

endmodule

/* hdl/wcgs_scan.sv */
// ----------------------------------------------------------------------------
// wcgs_scan
// Per-sample run tracker: follows the current clear run and the longest one,
// and hands over a summary at the end of each scan.
// ----------------------------------------------------------------------------
module wcgs_scan (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic [wcgs_pkg::RANGE_W-1:0]    range_value,
  input  logic                            last_sample,
  input  logic [wcgs_pkg::THR_W-1:0]      clear_threshold,
  output wcgs_pkg::scan_sum_t             summary,
  output logic                            summary_valid
);
  import wcgs_pkg::*;

  logic [CNT_W-1:0] sample_index, sample_index_next;
  logic [CNT_W-1:0] current_run, current_run_next;
  logic [CNT_W-1:0] best_run, best_run_next;
  logic [IDX_W-1:0] best_start, best_start_next;
  logic [IDX_W-1:0] best_end, best_end_next;
  logic             overflow_seen, overflow_seen_next;
  logic [CNT_W-1:0] first_idx;

  always_comb begin
    sample_index_next  = sample_index;
    current_run_next   = current_run;
    best_run_next      = best_run;
    best_start_next    = best_start;
    best_end_next      = best_end;
    overflow_seen_next = overflow_seen;
    first_idx          = sample_index + CNT_W'(1) - (current_run + CNT_W'(1));
    if (sample_index < CNT_W'(MAX_SAMPLES)) begin
      if (range_value > clear_threshold) begin
        current_run_next = current_run + CNT_W'(1);
        if (current_run_next > best_run) begin
          best_run_next   = current_run_next;
          best_start_next = first_idx[IDX_W-1:0];
          best_end_next   = sample_index[IDX_W-1:0];
        end
      end else begin
        current_run_next = '0;
      end
      sample_index_next = sample_index + CNT_W'(1);
    end else begin
      overflow_seen_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index  <= '0;
      current_run   <= '0;
      best_run      <= '0;
      best_start    <= '0;
      best_end      <= '0;
      overflow_seen <= 1'b0;
      summary_valid <= 1'b0;
    end else begin
      summary_valid <= 1'b0;
      if (take) begin
        if (last_sample) begin
          sample_index  <= '0;
          current_run   <= '0;
          best_run      <= '0;
          best_start    <= '0;
          best_end      <= '0;
          overflow_seen <= 1'b0;
          summary_valid <= 1'b1;
        end else begin
          sample_index  <= sample_index_next;
          current_run   <= current_run_next;
          best_run      <= best_run_next;
          best_start    <= best_start_next;
          best_end      <= best_end_next;
          overflow_seen <= overflow_seen_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && last_sample) begin
      summary.run_start    <= best_start_next;
      summary.run_end      <= best_end_next;
      summary.run_length   <= best_run_next;
      summary.center_twice <= SUM_W'(best_start_next) + SUM_W'(best_end_next);
      summary.scan_length  <= sample_index_next;
      summary.too_long     <= overflow_seen_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_best_within_scan: assert property (@(posedge clk) disable iff (rst)
    best_run <= sample_index)
    else $error("longest run exceeds samples seen");

  a_run_within_best: assert property (@(posedge clk) disable iff (rst)
    current_run <= best_run)
    else $error("current run exceeds longest run");

  a_cleared_after_last: assert property (@(posedge clk) disable iff (rst)
    summary_valid |-> (sample_index == '0))
    else $error("scan state not cleared after last sample");
`endif

endmodule

/* hdl/wcgs_steer.sv */
// ----------------------------------------------------------------------------
// wcgs_steer
// Steering sequencer: forms the signed numerator, then divides it by the scan
// length with one shared restoring subtract step per cycle.
// ----------------------------------------------------------------------------
module wcgs_steer (
  input  logic                                clk,
  input  logic                                rst,
  input  wcgs_pkg::steer_ctl_t                ctl,
  input  logic [wcgs_pkg::SPAN_W-1:0]         half_span,
  input  logic [wcgs_pkg::NEUT_W-1:0]         neutral,
  input  logic [wcgs_pkg::SUM_W-1:0]          center_twice,
  input  logic [wcgs_pkg::CNT_W-1:0]          scan_length,
  output logic                                idle,
  output logic                                done,
  output logic signed [wcgs_pkg::STEER_W-1:0] steer_command
);
  import wcgs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ADD  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } steer_state_t;

  steer_state_t state, state_next;

  logic [SUM_W-1:0]        center_q;
  logic [CNT_W-1:0]        len_q;
  logic [SPAN_W-1:0]       span_q;
  logic [NEUT_W-1:0]       neut_q;
  logic [P1_W-1:0]         p1;
  logic signed [NUM_W-1:0] p2;
  logic signed [NUM_W-1:0] num;
  logic signed [DIFF_W-1:0] diff;
  logic [NUM_W-1:0]        num_abs;
  logic                    neg;
  logic [CNT_W-1:0]        rem;
  logic [MAG_W-1:0]        quot;
  logic [ITER_W-1:0]       count;
  logic [CNT_W:0]          shifted;
  logic [CNT_W:0]          trial;
  logic                    fits;
  logic [STEER_W-1:0]      quot_trunc;

  assign diff    = $signed(DIFF_W'(neut_q)) - $signed(DIFF_W'(span_q));
  assign num     = $signed(NUM_W'(p1)) + p2;
  assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign shifted = {rem, quot[MAG_W-1]};
  assign trial   = shifted - {1'b0, len_q};
  assign fits    = shifted >= {1'b0, len_q};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (ctl.start) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = ST_DIV;
      ST_DIV:  if (count == '0) state_next = ST_DONE;
      ST_DONE: if (ctl.ack) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        center_q <= center_twice;
        len_q    <= scan_length;
        span_q   <= half_span;
        neut_q   <= neutral;
      end
      ST_MUL: begin
        p1 <= P1_W'(span_q) * P1_W'(center_q);
        p2 <= NUM_W'(diff) * $signed(NUM_W'(len_q));
      end
      ST_ADD: begin
        neg   <= num[NUM_W-1];
        quot  <= num_abs[MAG_W-1:0];
        rem   <= '0;
        count <= ITER_W'(MAG_W - 1);
      end
      ST_DIV: begin
        rem   <= fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
        quot  <= {quot[MAG_W-2:0], fits};
        count <= count - ITER_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign quot_trunc    = quot[STEER_W-1:0];
  assign steer_command = neg ? $signed(-quot_trunc) : $signed(quot_trunc);
  assign idle          = (state == ST_IDLE);
  assign done          = (state == ST_DONE);

endmodule

/* tb/widest_clear_gap_steering_checker.sv */
// ----------------------------------------------------------------------------
// widest_clear_gap_steering_checker
// Watches the register port and both stream channels of the gap steering
// unit. It tracks clear runs per scan, predicts each gap result and compares
// it field by field with what the unit sends.
// ----------------------------------------------------------------------------
module widest_clear_gap_steering_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [wcgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wcgs_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [wcgs_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tlast,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [wcgs_pkg::M_TDATA_W-1:0]  m_tdata,
  output int                              failures,
  output int                              gaps_checked,
  output int                              overflow_scans
);
  timeunit 1ns;
  timeprecision 1ps;
  import wcgs_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                too_long;
    logic [STEER_W-1:0]  steer_command;
    logic [CENTER_W-1:0] center_twice;
    logic [LENGTH_W-1:0] run_length;
    logic [START_W-1:0]  run_end;
    logic [START_W-1:0]  run_start;
  } gap_result_t;

  logic [THR_W-1:0]  threshold;
  logic [SPAN_W-1:0] half_span;
  logic [NEUT_W-1:0] neutral;

  int scan_pos;
  int run_now;
  int run_best;
  int best_first;
  int best_last;
  bit overflowed;

  gap_result_t gap_q[$];
  int mismatches;
  int results;
  int overlong;

  task automatic clear_scan();
    scan_pos   = 0;
    run_now    = 0;
    run_best   = 0;
    best_first = 0;
    best_last  = 0;
    overflowed = 1'b0;
  endtask

  task automatic track_sample(input logic [RANGE_W-1:0] range, input logic last);
    int len;
    int span_i;
    int num;
    int steer;
    gap_result_t gap;
    if (scan_pos < MAX_SAMPLES) begin
      if (range > threshold) begin
        run_now++;
        if (run_now > run_best) begin
          run_best   = run_now;
          best_first = scan_pos + 1 - run_best;
          best_last  = scan_pos;
        end
      end else begin
        run_now = 0;
      end
      scan_pos++;
    end else begin
      overflowed = 1'b1;
    end
    if (last) begin
      len    = scan_pos;
      span_i = int'(half_span);
      num    = span_i * (best_first + best_last) + (int'(neutral) - span_i) * len;
      steer  = num / len;
      gap.run_start     = START_W'(best_first);
      gap.run_end       = START_W'(best_last);
      gap.run_length    = LENGTH_W'(run_best);
      gap.center_twice  = CENTER_W'(best_first + best_last);
      gap.steer_command = STEER_W'(steer);
      gap.too_long      = overflowed;
      gap_q.push_back(gap);
      clear_scan();
    end
  endtask

  task automatic check_field(input string field, input int want_v, input int got_v);
    if (want_v != got_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("gap result %0d: %s expected %0d, got %0d", results, field, want_v, got_v);
      end
    end
  endtask

  always @(posedge clk) begin
    gap_result_t got;
    gap_result_t want;
    if (rst) begin
      threshold = THR_RESET;
      half_span = SPAN_RESET;
      neutral   = NEUT_RESET;
      clear_scan();
      gap_q.delete();
      mismatches = 0;
      results    = 0;
      overlong   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD: threshold = cfg_data[THR_W-1:0];
          CFG_HALF_SPAN: half_span = cfg_data[SPAN_W-1:0];
          CFG_NEUTRAL:   neutral   = cfg_data[NEUT_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = gap_result_t'(m_tdata[OUT_BITS-1:0]);
        results++;
        if (gap_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("gap result %0d arrived with none pending: %h", results, got);
          end
        end else begin
          want = gap_q.pop_front();
          check_field("run_start", int'(want.run_start), int'(got.run_start));
          check_field("run_end", int'(want.run_end), int'(got.run_end));
          check_field("run_length", int'(want.run_length), int'(got.run_length));
          check_field("center_twice", int'(want.center_twice), int'(got.center_twice));
          check_field("steer_command", int'($signed(want.steer_command)),
                      int'($signed(got.steer_command)));
          check_field("too_long", int'(want.too_long), int'(got.too_long));
          if (want.too_long) begin
            overlong++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        track_sample(s_tdata[RANGE_W-1:0], s_tlast);
      end
    end
    failures       <= mismatches + gap_q.size();
    gaps_checked   <= results;
    overflow_scans <= overlong;
  end

endmodule

/* tb/widest_clear_gap_steering_unit_test.sv */
// ----------------------------------------------------------------------------
// widest_clear_gap_steering_unit_test
// Drives scans of range samples through the gap steering unit under several
// register settings, with random gaps on the sample side and random stalls on
// the result side, and lets the checker judge every gap result.
// ----------------------------------------------------------------------------
module widest_clear_gap_steering_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wcgs_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 9;
  localparam int IDLE_PCT       = 31;
  localparam int HOLD_CYCLES    = 240;
  localparam int STALL_LIMIT    = 4000;
  localparam int TAIL_CYCLES    = 40;
  localparam int RANDOM_SAMPLES = 200;
  localparam int PHASES         = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {
    FILL_RAW,
    FILL_NEAR,
    FILL_STRIPES,
    FILL_MOSTLY_CLEAR,
    FILL_ALL_CLEAR,
    FILL_ALL_BLOCKED
  } fill_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;   // range_value
  logic                  s_tlast = 1'b0; // last_sample
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // run_start, run_end, run_length, center_twice, steer_command, too_long
  logic [M_TDATA_W-1:0]  m_tdata;

  int failures;
  int gaps_checked;
  int overflow_scans;

  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  int scans_sent = 0;
  int samples_sent = 0;
  int quiet_cycles = 0;
  logic [THR_W-1:0] thr_now = THR_RESET;

  widest_clear_gap_steering_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  widest_clear_gap_steering_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .failures       (failures),
    .gaps_checked   (gaps_checked),
    .overflow_scans (overflow_scans)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold off results for a long stretch on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      m_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_sample(input logic [RANGE_W-1:0] range, input logic last);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= range;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    samples_sent++;
    if (last) begin
      scans_sent++;
    end
  endtask

  function automatic logic [RANGE_W-1:0] pick_range(input bit clear);
    if (clear) begin
      if (thr_now == '1 || $urandom_range(7) == 0) begin
        return '1;
      end
      return RANGE_W'($urandom_range(65535, int'(thr_now) + 1));
    end
    if ($urandom_range(7) == 0) begin
      return '0;
    end
    return RANGE_W'($urandom_range(int'(thr_now), 0));
  endfunction

  task automatic send_scan(input int len, input fill_t fill);
    int period;
    int near;
    logic [RANGE_W-1:0] range;
    period = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_RAW: range = RANGE_W'($urandom);
        FILL_NEAR: begin
          near = int'(thr_now) + int'($urandom_range(2)) - 1;
          range = (near < 0) ? '0 : (near > 65535) ? '1 : RANGE_W'(near);
        end
        FILL_STRIPES:      range = pick_range(((i / period) % 2) == 0);
        FILL_MOSTLY_CLEAR: range = pick_range($urandom_range(99) < 75);
        FILL_ALL_CLEAR:    range = pick_range(1'b1);
        default:           range = pick_range(1'b0);
      endcase
      send_sample(range, i == len - 1);
    end
  endtask

  // wait out pending results and the divide before touching registers
  task automatic drain();
    s_tvalid <= 1'b0;
    while (gaps_checked != scans_sent) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] span,
                          input logic [CFG_W-1:0] neut);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_HALF_SPAN, span);
    write_reg(CFG_NEUTRAL, neut);
    cfg_we  <= 1'b0;
    thr_now = thr[THR_W-1:0];
  endtask

  task automatic random_phase(input int samples);
    int budget;
    int len;
    budget = samples;
    while (budget > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      send_scan(len, fill_t'($urandom_range(FILL_ALL_BLOCKED)));
      budget -= len;
    end
    drain();
  endtask

  initial begin
    logic [RANGE_W-1:0] tie_scan[7] = '{16'd41, 16'd40, 16'd41, 16'd41, 16'd0,
                                        16'hFFFF, 16'hFFFF};
    logic [RANGE_W-1:0] clear_scan[4] = '{16'd41, 16'd100, 16'hFFFF, 16'd50000};
    logic [RANGE_W-1:0] head_scan[3] = '{16'hFFFF, 16'd40, 16'd40};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(16'd0, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    foreach (tie_scan[i]) send_sample(tie_scan[i], i == 6);
    foreach (clear_scan[i]) send_sample(clear_scan[i], i == 3);
    foreach (head_scan[i]) send_sample(head_scan[i], i == 2);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_regs(16'd0, 16'd0, 16'd0);
        1: begin
          write_reg(CFG_SPARE, 16'h1234);
          set_regs(16'hFFFF, 16'hFF7F, 16'hABFF);
        end
        2: begin
          set_regs(16'd1000, 16'd90, 16'd180);
          gaps_on = 1'b0;
        end
        3: begin
          set_regs(16'd40, 16'd127, 16'd0);
          hold_req = 1'b1;
        end
        4: set_regs(16'd40, 16'd0, 16'd255);
        default: set_regs(($urandom_range(1) != 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(300)),
                          CFG_W'($urandom_range(127)), CFG_W'($urandom_range(255)));
      endcase
      random_phase(RANDOM_SAMPLES / PHASES);
      gaps_on = 1'b1;
      if (p == 3) begin
        send_scan(MAX_SAMPLES + 1, FILL_MOSTLY_CLEAR);
        drain();
      end
    end

    drain();
    $display("Checked %0d gap results from %0d samples (%0d overlong scans)",
             gaps_checked, samples_sent, overflow_scans);
    $display("over reset, extreme and random register values with stalls on both sides");
    if (failures == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/wcgs_pkg.sv
hdl/wcgs_scan.sv
hdl/wcgs_steer.sv
hdl/widest_clear_gap_steering_unit.sv
tb/widest_clear_gap_steering_checker.sv
tb/widest_clear_gap_steering_unit_test.sv
